[rtl/ddiff_pkg.sv]
// types, constants and calendar helpers shared by the date difference unit
// no dependencies; imported by ddiff_front, ddiff_queue, ddiff_back and the top level
`default_nettype none

package ddiff_pkg;

   localparam int unsigned DayW    = 5;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned YearW   = 14;
   localparam int unsigned CentW   = 8;
   localparam int unsigned SerialW = 22;
   localparam int unsigned DiffW   = 23;

   // floor(y / 100) == (y * RecipHundred) >> RecipShift for every 14-bit y
   localparam logic [12:0] RecipHundred = 13'd5243;
   localparam int unsigned RecipShift   = 19;
   localparam int unsigned RecipProdW   = YearW + 13;

   localparam logic [YearW-1:0] YearMin = 14'd1;
   localparam logic [YearW-1:0] YearMax = 14'd9999;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_CHECK
   } ddiff_front_state_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_SERIAL,
      BE_DIFF
   } ddiff_back_state_type;

   typedef struct packed {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [CentW-1:0]  cent;        // year / 100
      logic              cent_exact;  // year is a multiple of 100
      logic              leap;
   } ddiff_date_type;

   typedef struct packed {
      logic           invalid;
      logic           negate;
      logic           include_end;
      ddiff_date_type early;
      ddiff_date_type late;
   } ddiff_entry_type;

   function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] month,
                                                     input logic leap);
      logic [DayW-1:0] dim;
      case (month)
         4'd2:                                     dim = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:                  dim = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: dim = 5'd31;
         default:                                  dim = 5'd0;
      endcase
      return dim;
   endfunction

   function automatic logic [8:0] month_start(input logic [MonthW-1:0] month);
      logic [8:0] ms;
      case (month)
         4'd1:    ms = 9'd0;
         4'd2:    ms = 9'd31;
         4'd3:    ms = 9'd59;
         4'd4:    ms = 9'd90;
         4'd5:    ms = 9'd120;
         4'd6:    ms = 9'd151;
         4'd7:    ms = 9'd181;
         4'd8:    ms = 9'd212;
         4'd9:    ms = 9'd243;
         4'd10:   ms = 9'd273;
         4'd11:   ms = 9'd304;
         4'd12:   ms = 9'd334;
         default: ms = 9'd0;
      endcase
      return ms;
   endfunction

   // day number of a valid date, 1 january of year 1 is day 1
   function automatic logic [SerialW-1:0] serial_day(input ddiff_date_type dt);
      logic [YearW-1:0]   p;
      logic [CentW-1:0]   pc;
      logic [SerialW-1:0] n;
      p  = dt.year - YearMin;
      // (year - 1) / 100 drops by one when year is a whole century
      pc = dt.cent - {{(CentW-1){1'b0}}, dt.cent_exact};
      n  = SerialW'(p) * 22'd365 + SerialW'(p[YearW-1:2]) - SerialW'(pc)
         + SerialW'(pc[CentW-1:2]) + SerialW'(month_start(dt.month)) + SerialW'(dt.day);
      if (dt.month > 4'd2 && dt.leap) begin
         n = n + 22'd1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/ddiff_front.sv]
// front end: takes one date pair, finds century and leap facts, validates and orders
// depends on ddiff_pkg; pushes ddiff_entry_type items into ddiff_queue
`default_nettype none

module ddiff_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [ddiff_pkg::DayW-1:0]   first_day,
   input  wire logic [ddiff_pkg::MonthW-1:0] first_month,
   input  wire logic [ddiff_pkg::YearW-1:0]  first_year,
   input  wire logic [ddiff_pkg::DayW-1:0]   second_day,
   input  wire logic [ddiff_pkg::MonthW-1:0] second_month,
   input  wire logic [ddiff_pkg::YearW-1:0]  second_year,
   input  wire logic                    include_end_day,
   input  wire logic                    queue_full,
   output logic                         push,
   output ddiff_pkg::ddiff_entry_type   push_entry
);
   import ddiff_pkg::*;

   ddiff_front_state_type state_ff, state_in;
   ddiff_date_type        first_ff, first_in;
   ddiff_date_type        second_ff, second_in;
   logic                  inc_ff, inc_in;

   logic [RecipProdW-1:0] first_prod, second_prod;
   ddiff_date_type        first_chk, second_chk;
   logic                  first_ok, second_ok, first_earlier;

   function automatic ddiff_date_type add_leap(input ddiff_date_type dt);
      ddiff_date_type  o;
      logic [YearW-1:0] rem;
      o   = dt;
      rem = dt.year - YearW'(dt.cent) * 14'd100;
      o.cent_exact = (rem == '0);
      o.leap = (dt.year[1:0] == 2'd0 && rem != '0) || (rem == '0 && dt.cent[1:0] == 2'd0);
      return o;
   endfunction

   function automatic logic date_ok(input ddiff_date_type dt);
      return dt.year >= YearMin && dt.year <= YearMax && dt.day != '0
          && dt.day <= days_in_month(dt.month, dt.leap);
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FE_IDLE:  if (req_valid) state_in = FE_DIV;
         FE_DIV:   state_in = FE_CHECK;
         FE_CHECK: if (!queue_full) state_in = FE_IDLE;
         default:  state_in = FE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == FE_IDLE);
      push      = (state_ff == FE_CHECK) && !queue_full;
   end

   // datapath
   always_comb begin
      first_prod  = RecipProdW'(first_ff.year) * RecipProdW'(RecipHundred);
      second_prod = RecipProdW'(second_ff.year) * RecipProdW'(RecipHundred);
      first_in  = first_ff;
      second_in = second_ff;
      inc_in    = inc_ff;
      if (state_ff == FE_IDLE && req_valid) begin
         first_in.day    = first_day;
         first_in.month  = first_month;
         first_in.year   = first_year;
         second_in.day   = second_day;
         second_in.month = second_month;
         second_in.year  = second_year;
         inc_in          = include_end_day;
      end else if (state_ff == FE_DIV) begin
         first_in.cent  = first_prod[RecipShift +: CentW];
         second_in.cent = second_prod[RecipShift +: CentW];
      end

      first_chk  = add_leap(first_ff);
      second_chk = add_leap(second_ff);
      first_ok   = date_ok(first_chk);
      second_ok  = date_ok(second_chk);
      first_earlier = (first_ff.year < second_ff.year)
         || (first_ff.year == second_ff.year && first_ff.month < second_ff.month)
         || (first_ff.year == second_ff.year && first_ff.month == second_ff.month
             && first_ff.day < second_ff.day);

      push_entry.invalid     = !(first_ok && second_ok);
      push_entry.negate      = !first_earlier;
      push_entry.include_end = inc_ff;
      push_entry.early       = first_earlier ? first_chk : second_chk;
      push_entry.late        = first_earlier ? second_chk : first_chk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      inc_ff    <= inc_in;
   end

endmodule

`default_nettype wire

[rtl/ddiff_queue.sv]
// short fifo of classified date pairs between front and back end
// depends on ddiff_pkg for ddiff_entry_type
`default_nettype none

module ddiff_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ddiff_pkg::ddiff_entry_type push_entry,
   input  wire logic                  pop,
   output ddiff_pkg::ddiff_entry_type pop_entry,
   output logic                       full,
   output logic                       empty
);
   import ddiff_pkg::*;

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   ddiff_entry_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CntW'(DEPTH));
      empty     = (count_ff == '0);
      pop_entry = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");
`endif

endmodule

`default_nettype wire

[rtl/ddiff_back.sv]
// back end: day numbers of both dates, signed difference, output register
// depends on ddiff_pkg; pops ddiff_entry_type items from ddiff_queue
`default_nettype none

module ddiff_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  queue_empty,
   input  wire ddiff_pkg::ddiff_entry_type pop_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [ddiff_pkg::DiffW-1:0] day_difference,
   output logic                       invalid_date
);
   import ddiff_pkg::*;

   ddiff_back_state_type state_ff, state_in;
   ddiff_entry_type      ent_ff, ent_in;
   logic [SerialW-1:0]   early_ser_ff, early_ser_in;
   logic [SerialW-1:0]   late_ser_ff, late_ser_in;
   logic                 out_valid_ff, out_valid_in;
   logic [DiffW-1:0]     out_diff_ff, out_diff_in;
   logic                 out_inv_ff, out_inv_in;

   logic                 out_free, load_out;
   logic [DiffW-1:0]     count;

   assign out_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE:   if (!queue_empty) state_in = BE_SERIAL;
         BE_SERIAL: state_in = BE_DIFF;
         BE_DIFF:   if (out_free) state_in = BE_IDLE;
         default:   state_in = BE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = (state_ff == BE_IDLE) && !queue_empty;
      load_out = (state_ff == BE_DIFF) && out_free;
   end

   // datapath
   always_comb begin
      ent_in       = pop ? pop_entry : ent_ff;
      early_ser_in = early_ser_ff;
      late_ser_in  = late_ser_ff;
      if (state_ff == BE_SERIAL) begin
         early_ser_in = serial_day(ent_ff.early);
         late_ser_in  = serial_day(ent_ff.late);
      end

      count = DiffW'(late_ser_ff) - DiffW'(early_ser_ff) + DiffW'(ent_ff.include_end);

      out_valid_in = out_valid_ff;
      out_diff_in  = out_diff_ff;
      out_inv_in   = out_inv_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_inv_in   = ent_ff.invalid;
         if (ent_ff.invalid) begin
            out_diff_in = '0;
         end else begin
            out_diff_in = ent_ff.negate ? -count : count;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      ent_ff       <= ent_in;
      early_ser_ff <= early_ser_in;
      late_ser_ff  <= late_ser_in;
      out_diff_ff  <= out_diff_in;
      out_inv_ff   <= out_inv_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign day_difference = out_diff_ff;
   assign invalid_date   = out_inv_ff;

endmodule

`default_nettype wire

[rtl/date_difference_in_days_unit.sv]
// top level of the gregorian date difference unit
// depends on ddiff_pkg, ddiff_front, ddiff_queue and ddiff_back
`default_nettype none

// usage
//   req channel: one beat carries two dates and an include-end-day flag; the beat is
//   taken when req_tvalid and req_tready are both high. rsp channel: one beat per
//   request, in request order, with the signed day count from the first date to the
//   second (negative when the first date is not strictly earlier, equal dates count
//   as swapped) and an invalid flag in rsp_tuser (count then reads zero).
// path: from the accepting edge to rsp_tvalid when nothing stalls, a request passes
//   the front's century divide and check steps, the queue, the day-number
//   step and the difference step into the output register
// pacing: the front takes a new beat only once its three-step sequencer is back in
//   idle; the back end also runs three steps per beat, so neither side limits the other
// stalls: a held rsp beat keeps the back end in its difference step, the queue
//   then fills and the front drops req_tready; the front still takes one request
//   while idle and holds it until the queue has room, so up to QUEUE_DEPTH + 3
//   requests can be in flight (front, queue, back end and output register)
// reset: synchronous, active high; empties the queue and returns both
//   sequencers to idle, no result is pending afterwards

module date_difference_in_days_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: first_day[4:0] first_month[8:5] first_year[22:9] second_day[27:23]
   //          second_month[31:28] second_year[45:32] include_end_day[46], zero fill[47]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // response: day_difference[22:0] signed, zero fill[23]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   // response tuser: invalid_date[0]
   output logic             rsp_tuser
);
   import ddiff_pkg::*;

   ddiff_entry_type  push_entry, pop_entry;
   logic             push, pop, queue_full, queue_empty;
   logic [DiffW-1:0] day_difference;

   // classify: validate both dates, order them, precompute century facts
   ddiff_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .first_day       (req_tdata[4:0]),
      .first_month     (req_tdata[8:5]),
      .first_year      (req_tdata[22:9]),
      .second_day      (req_tdata[27:23]),
      .second_month    (req_tdata[31:28]),
      .second_year     (req_tdata[45:32]),
      .include_end_day (req_tdata[46]),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   // decouples the two halves so each can stall on its own
   ddiff_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // execute: day numbers in closed form, signed difference, output register
   ddiff_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .day_difference (day_difference),
      .invalid_date   (rsp_tuser)
   );

   // pad the count to a whole byte
   assign rsp_tdata = {1'b0, day_difference};

endmodule

`default_nettype wire
